// File: design/rmb_pkg.sv
// Shared types and constants for the rotating mono blit address generator.
// Used by the lane, merge and top-level modules; depends on nothing else.
package rmb_pkg;

  // Number of pixels carried by one source byte, one lane per pixel.
  localparam int NUM_LANES = 8;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_DEST_X       = 3'd0;
  localparam logic [2:0] CFG_DEST_Y       = 3'd1;
  localparam logic [2:0] CFG_SRC_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_SRC_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_BLIT_MODE    = 3'd4;
  localparam logic [2:0] CFG_FILL_COLOR   = 3'd5;
  localparam logic [2:0] CFG_PLANE_ENABLE = 3'd6;

  // Blit modes. Codes above MODE_FILL are treated as MODE_PLAIN.
  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_INVERT = 3'd1,
    MODE_GRAY   = 3'd2,
    MODE_LAND   = 3'd3,
    MODE_FILL   = 3'd4
  } mode_t;

  // Settings and item position shared by all lanes.
  typedef struct packed {
    mode_t              mode;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [10:0]        src_width;
    logic [10:0]        src_height;
    logic               fill_color;
    logic [1:0]         plane_enable;
    logic               row_ok;
    logic [10:0]        row_count;
  } lane_ctl_t;

  // One framebuffer bit write.
  typedef struct packed {
    logic [15:0] byte_addr;
    logic [2:0]  bit_index;
    logic        write_bw;
    logic        bw_value;
    logic        write_gs;
    logic        gs_value;
  } wr_t;

endpackage

// File: design/rotating_mono_blit_address_gen.sv
// A request accepted into the lane stage passes the merge stage and the output
// register before its first bit write; later writes of the same byte follow
// one per cycle while wr_stall is low. The merge stage sends one write per
// visible pixel of a source byte (up to 8), and none when no pixel is
// visible. Synchronous reset clears the counters, the pipeline valids and the
// registers to their defaults (plane_enable to 3).
module rotating_mono_blit_address_gen import rmb_pkg::*; #(
  parameter int PANEL_SHORT = 480,
  parameter int PANEL_LONG  = 800,
  parameter int ROW_BYTES   = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  bw_byte,
  input  logic [7:0]  gs_byte,
  output logic        wr_valid,
  input  logic        wr_stall,
  output logic [15:0] byte_addr,
  output logic [2:0]  bit_index,
  output logic        write_bw,
  output logic        bw_value,
  output logic        write_gs,
  output logic        gs_value,
  output logic        last_write
);

  logic signed [11:0] dest_x;
  logic signed [11:0] dest_y;
  logic [10:0]        src_width;
  logic [10:0]        src_height;
  logic [2:0]         blit_mode;
  logic               fill_color;
  logic [1:0]         plane_enable;

  logic [7:0]         column_byte_count;
  logic [10:0]        row_count;
  logic [7:0]         column_byte_count_next;
  logic [11:0]        row_inc;
  logic [8:0]         stride;

  lane_ctl_t               ctl;
  logic                    ld1;
  logic                    ld2;
  logic [NUM_LANES-1:0]    s1_mask;
  wr_t [NUM_LANES-1:0]     lane_wr;
  wr_t                     wr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x       <= '0;
      dest_y       <= '0;
      src_width    <= '0;
      src_height   <= '0;
      blit_mode    <= '0;
      fill_color   <= 1'b0;
      plane_enable <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_X:       dest_x       <= $signed(cfg_data);
        CFG_DEST_Y:       dest_y       <= $signed(cfg_data);
        CFG_SRC_WIDTH:    src_width    <= cfg_data[10:0];
        CFG_SRC_HEIGHT:   src_height   <= cfg_data[10:0];
        CFG_BLIT_MODE:    blit_mode    <= cfg_data[2:0];
        CFG_FILL_COLOR:   fill_color   <= cfg_data[0];
        CFG_PLANE_ENABLE: plane_enable <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake on the source side.
  assign src_stall = (|s1_mask) && !ld2;
  assign ld1       = src_valid && !src_stall;

  // Source position counters advance once per accepted byte.
  assign stride                 = 9'((12'(src_width) + 12'd7) >> 3);
  assign column_byte_count_next = column_byte_count + 8'd1;
  assign row_inc                = 12'(row_count) + 12'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_byte_count <= '0;
      row_count         <= '0;
    end else if (ld1) begin
      if ((column_byte_count_next == 8'd0) ||
          ({1'b0, column_byte_count_next} >= stride)) begin
        column_byte_count <= '0;
        row_count         <= (row_inc >= 12'(src_height)) ? 11'd0 : row_inc[10:0];
      end else begin
        column_byte_count <= column_byte_count_next;
      end
    end
  end

  // Settings shared by the lanes.
  always_comb begin
    ctl.mode         = (blit_mode <= MODE_FILL) ? mode_t'(blit_mode) : MODE_PLAIN;
    ctl.dest_x       = dest_x;
    ctl.dest_y       = dest_y;
    ctl.src_width    = src_width;
    ctl.src_height   = src_height;
    ctl.fill_color   = fill_color;
    ctl.plane_enable = plane_enable;
    ctl.row_ok       = row_count < src_height;
    ctl.row_count    = row_count;
  end

  // One lane per pixel of the byte, leftmost pixel in lane 0.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rmb_lane #(
      .PANEL_SHORT (PANEL_SHORT),
      .PANEL_LONG  (PANEL_LONG),
      .ROW_BYTES   (ROW_BYTES)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .col    ({column_byte_count, 3'(i)}),
      .pix_bw (bw_byte[NUM_LANES-1-i]),
      .pix_gs (gs_byte[NUM_LANES-1-i]),
      .ld1    (ld1),
      .ld2    (ld2),
      .hit    (s1_mask[i]),
      .result (lane_wr[i])
    );
  end

  // Serialize the hits onto the write channel.
  rmb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .s1_mask    (s1_mask),
    .lane_wr    (lane_wr),
    .ld2        (ld2),
    .wr_valid   (wr_valid),
    .wr_stall   (wr_stall),
    .wr         (wr),
    .last_write (last_write)
  );

  assign byte_addr = wr.byte_addr;
  assign bit_index = wr.bit_index;
  assign write_bw  = wr.write_bw;
  assign bw_value  = wr.bw_value;
  assign write_gs  = wr.write_gs;
  assign gs_value  = wr.gs_value;

`ifndef SYNTH
  // Reset empties the pipeline and the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!wr_valid && (s1_mask == '0)))
    else $error("pipeline not empty after reset");

  // Every write touches at least one plane.
  a_plane_written: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (write_bw || write_gs))
    else $error("write with no plane enabled");

  // A plane that is not written carries a zero value.
  a_value_masked: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> ((write_bw || !bw_value) && (write_gs || !gs_value)))
    else $error("value set on a plane that is not written");

  // The lane stage is never overwritten while it still holds hits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ld1 |-> ((s1_mask == '0) || ld2))
    else $error("lane stage overwritten");
`endif

endmodule

// File: design/rmb_lane.sv
// One pixel lane: places, rotates and clips one source pixel, then forms its
// framebuffer byte address. Depends on rmb_pkg.
module rmb_lane import rmb_pkg::*; #(
  parameter int PANEL_SHORT = 480,
  parameter int PANEL_LONG  = 800,
  parameter int ROW_BYTES   = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctl_t  ctl,
  input  logic [10:0] col,
  input  logic       pix_bw,
  input  logic       pix_gs,
  input  logic       ld1,
  input  logic       ld2,
  output logic       hit,
  output wr_t        result
);

  localparam int LROW_W = $clog2(PANEL_SHORT);
  localparam int LCOL_W = ($clog2(PANEL_LONG) > 3) ? $clog2(PANEL_LONG) : 4;
  localparam int RB_W   = $clog2(ROW_BYTES + 1);
  localparam int SUM_W  = LROW_W + RB_W + 1;

  logic [10:0]        flip_row;
  logic signed [13:0] px;
  logic signed [13:0] py;
  logic               in_src;
  logic               on_panel;
  logic               wbw, vbw, wgs, vgs;
  logic               hit_next;

  logic [LROW_W-1:0]  lrow;
  logic [LCOL_W-1:0]  lcol;
  logic [3:0]         planes;
  logic [SUM_W-1:0]   sum;

  // Portrait placement; landscape sources are turned by a quarter turn.
  always_comb begin
    flip_row = ctl.src_height - 11'd1 - ctl.row_count;
    if (ctl.mode == MODE_LAND) begin
      px = 14'(ctl.dest_x) + $signed({3'b000, flip_row});
      py = 14'(ctl.dest_y) + $signed({3'b000, col});
    end else begin
      px = 14'(ctl.dest_x) + $signed({3'b000, col});
      py = 14'(ctl.dest_y) + $signed({3'b000, ctl.row_count});
    end
  end

  // Clip against the source rectangle and the panel.
  assign in_src   = ctl.row_ok && (col < ctl.src_width);
  assign on_panel = !px[13] && (px < $signed(14'(PANEL_SHORT))) &&
                    !py[13] && (py < $signed(14'(PANEL_LONG)));

  // Plane enables and values per mode.
  always_comb begin
    wbw = 1'b1;
    vbw = pix_bw;
    wgs = 1'b0;
    vgs = 1'b0;
    case (ctl.mode)
      MODE_INVERT: begin
        vbw = ~pix_bw;
      end
      MODE_GRAY: begin
        wgs = 1'b1;
        vgs = pix_gs;
      end
      MODE_LAND: begin
        wbw = ctl.plane_enable[0];
        vbw = ctl.plane_enable[0] & pix_bw;
        wgs = ctl.plane_enable[1];
        vgs = ctl.plane_enable[1] & pix_gs;
      end
      MODE_FILL: begin
        vbw = ctl.fill_color;
      end
      default: begin
        vbw = pix_bw;
      end
    endcase
  end

  assign hit_next = in_src && on_panel && (wbw || wgs);

  // First stage: rotated landscape coordinates. The hit flag clears once
  // the merge stage has taken the item and nothing new arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ld1) begin
      hit <= hit_next;
    end else if (ld2) begin
      hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      lrow   <= LROW_W'(PANEL_SHORT - 1) - px[LROW_W-1:0];
      lcol   <= py[LCOL_W-1:0];
      planes <= {wbw, vbw, wgs, vgs};
    end
  end

  // Second stage: row times stride plus column byte.
  assign sum = SUM_W'(lrow) * SUM_W'(ROW_BYTES) + SUM_W'(lcol[LCOL_W-1:3]);

  always_ff @(posedge clk) begin
    if (ld2) begin
      result.byte_addr <= 16'(sum);
      result.bit_index <= ~lcol[2:0];
      result.write_bw  <= planes[3];
      result.bw_value  <= planes[2];
      result.write_gs  <= planes[1];
      result.gs_value  <= planes[0];
    end
  end

endmodule

// File: design/rmb_merge.sv
// Merge stage: holds the lane results of one source byte and sends the hits out one per
// cycle unless stalled, lowest lane first, through an output register. Depends on rmb_pkg.
module rmb_merge import rmb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [NUM_LANES-1:0]  s1_mask,
  input  wr_t [NUM_LANES-1:0]   lane_wr,
  output logic                  ld2,
  output logic                  wr_valid,
  input  logic                  wr_stall,
  output wr_t                   wr,
  output logic                  last_write
);

  logic [NUM_LANES-1:0] mask;
  logic [NUM_LANES-1:0] low_bit;
  logic [NUM_LANES-1:0] rest;
  logic [$clog2(NUM_LANES)-1:0] sel;
  logic                 pop;
  logic                 free_next;

  // Pick the lowest pending lane.
  always_comb begin
    sel = '0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = ($clog2(NUM_LANES))'(i);
      end
    end
  end

  assign low_bit   = mask & (~mask + NUM_LANES'(1));
  assign rest      = mask & ~low_bit;
  assign pop       = (|mask) && (!wr_valid || !wr_stall);
  assign free_next = (mask == '0) || (pop && (rest == '0));
  assign ld2       = (|s1_mask) && free_next;

  // Pending lane mask of the byte being sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (ld2) begin
      mask <= s1_mask;
    end else if (pop) begin
      mask <= rest;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (pop) begin
      wr_valid <= 1'b1;
    end else if (!wr_stall) begin
      wr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      wr         <= lane_wr[sel];
      last_write <= (rest == '0);
    end
  end

endmodule

// File: bench/rotating_mono_blit_address_gen_test.sv
// Self-checking bench for the rotating mono blit address generator.
// Sends source bytes under random idling, predicts each framebuffer bit write
// and checks the write channel in order; depends on rmb_pkg and the block.
module rotating_mono_blit_address_gen_test;
  import rmb_pkg::*;

  localparam int PANEL_SHORT  = 480;
  localparam int PANEL_LONG   = 800;
  localparam int ROW_BYTES    = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 185;
  // Highest mode code; codes above MODE_FILL behave as plain.
  localparam logic [2:0] MODE_CODE_TOP = 3'd7;

  typedef struct packed {
    logic [7:0] bw;
    logic [7:0] gs;
  } src_byte_t;

  typedef struct packed {
    wr_t  wr;
    logic last;
  } bit_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DEST_X;
  logic [11:0] cfg_data = '0;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  bw_byte = '0;
  logic [7:0]  gs_byte = '0;
  logic        wr_valid;
  logic        wr_stall = 1'b0;
  logic [15:0] byte_addr;
  logic [2:0]  bit_index;
  logic        write_bw;
  logic        bw_value;
  logic        write_gs;
  logic        gs_value;
  logic        last_write;

  // Register copies and source counters of the predictor.
  logic signed [11:0] cfg_dx = '0;
  logic signed [11:0] cfg_dy = '0;
  logic [10:0]        cfg_w = '0;
  logic [10:0]        cfg_h = '0;
  logic [2:0]         cfg_mode = MODE_PLAIN;
  logic               cfg_fill = 1'b0;
  logic [1:0]         cfg_planes = 2'd3;
  logic [7:0]         col_bytes = '0;
  logic [10:0]        row_idx = '0;

  src_byte_t  bytes_to_send[$];
  bit_write_t pending_writes[$];
  int         bytes_sent = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  int         send_idle_pct = 21;
  int         recv_idle_pct = 59;
  logic       src_took = 1'b0;

  rotating_mono_blit_address_gen dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .bw_byte    (bw_byte),
    .gs_byte    (gs_byte),
    .wr_valid   (wr_valid),
    .wr_stall   (wr_stall),
    .byte_addr  (byte_addr),
    .bit_index  (bit_index),
    .write_bw   (write_bw),
    .bw_value   (bw_value),
    .write_gs   (write_gs),
    .gs_value   (gs_value),
    .last_write (last_write)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Place the eight pixels of one source byte, queue the visible bit writes
  // and advance the column-byte and row counters.
  function automatic void predict_writes(input logic [7:0] bw, input logic [7:0] gs);
    int         stride, dx, dy, h, r, cb, col, px, py, n;
    mode_t      eff;
    bit_write_t burst[8];
    bit_write_t one;
    eff = (cfg_mode > MODE_FILL) ? MODE_PLAIN : mode_t'(cfg_mode);
    stride = (int'(cfg_w) + 7) >> 3;
    dx = cfg_dx;
    dy = cfg_dy;
    h = cfg_h;
    r = row_idx;
    cb = col_bytes;
    n = 0;
    if (r < h) begin
      for (int k = 0; k < 8; k++) begin
        col = cb * 8 + k;
        if (col >= int'(cfg_w)) break;
        if (eff == MODE_LAND) begin
          px = dx + (h - 1 - r);
          py = dy + col;
        end else begin
          px = dx + col;
          py = dy + r;
        end
        if (px < 0 || px >= PANEL_SHORT || py < 0 || py >= PANEL_LONG) continue;
        one = '0;
        case (eff)
          MODE_INVERT: begin
            one.wr.write_bw = 1'b1;
            one.wr.bw_value = ~bw[7 - k];
          end
          MODE_GRAY: begin
            one.wr.write_bw = 1'b1;
            one.wr.bw_value = bw[7 - k];
            one.wr.write_gs = 1'b1;
            one.wr.gs_value = gs[7 - k];
          end
          MODE_LAND: begin
            one.wr.write_bw = cfg_planes[0];
            one.wr.bw_value = cfg_planes[0] & bw[7 - k];
            one.wr.write_gs = cfg_planes[1];
            one.wr.gs_value = cfg_planes[1] & gs[7 - k];
          end
          MODE_FILL: begin
            one.wr.write_bw = 1'b1;
            one.wr.bw_value = cfg_fill;
          end
          default: begin
            one.wr.write_bw = 1'b1;
            one.wr.bw_value = bw[7 - k];
          end
        endcase
        if (!one.wr.write_bw && !one.wr.write_gs) continue;
        // Rotate portrait (px, py) into landscape row and column.
        one.wr.byte_addr = 16'((PANEL_SHORT - 1 - px) * ROW_BYTES + py / 8);
        one.wr.bit_index = 3'(7 - py % 8);
        burst[n] = one;
        n++;
      end
    end
    if (n > 0) burst[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_writes.push_back(burst[i]);

    cb = cb + 1;
    if (cb == 256 || cb >= stride) begin
      cb = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    col_bytes = 8'(cb);
    row_idx = 11'(r);
  endfunction

  // Request driver: a new byte goes out only after the last one was taken.
  always @(negedge clk) begin : drive_source
    src_byte_t next_byte;
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || src_took) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = bytes_to_send.pop_front();
        src_valid <= 1'b1;
        bw_byte <= next_byte.bw;
        gs_byte <= next_byte.gs;
      end else begin
        src_valid <= 1'b0;
      end
    end
    wr_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted write.
  always @(posedge clk) begin : watch_ports
    bit_write_t got, want;
    if (rst) begin
      src_took <= 1'b0;
    end else begin
      src_took <= src_valid && !src_stall;
      if (src_valid && !src_stall) begin
        predict_writes(bw_byte, gs_byte);
        bytes_taken++;
      end
      if (wr_valid && !wr_stall) begin
        got = {byte_addr, bit_index, write_bw, bw_value, write_gs, gs_value, last_write};
        if (pending_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected write: addr %0d bit %0d bw %b/%b gs %b/%b last %b",
                     got.wr.byte_addr, got.wr.bit_index, got.wr.write_bw,
                     got.wr.bw_value, got.wr.write_gs, got.wr.gs_value, got.last);
        end else begin
          want = pending_writes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("write mismatch: expected addr %0d bit %0d bw %b/%b gs %b/%b last %b",
                       want.wr.byte_addr, want.wr.bit_index, want.wr.write_bw,
                       want.wr.bw_value, want.wr.write_gs, want.wr.gs_value, want.last,
                       "; got addr %0d bit %0d bw %b/%b gs %b/%b last %b",
                       got.wr.byte_addr, got.wr.bit_index, got.wr.write_bw,
                       got.wr.bw_value, got.wr.write_gs, got.wr.gs_value, got.last);
          end
        end
      end
    end
  end

  // One register write; half the time junk lands in the unused upper bits.
  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    logic [11:0] mask, data;
    case (idx)
      CFG_DEST_X, CFG_DEST_Y:        mask = 12'hFFF;
      CFG_SRC_WIDTH, CFG_SRC_HEIGHT: mask = 12'h7FF;
      CFG_BLIT_MODE:                 mask = 12'h007;
      CFG_FILL_COLOR:                mask = 12'h001;
      default:                       mask = 12'h003;
    endcase
    data = val & mask;
    if ($urandom_range(1)) data = data | (12'($urandom) & ~mask);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEST_X:     cfg_dx = data;
      CFG_DEST_Y:     cfg_dy = data;
      CFG_SRC_WIDTH:  cfg_w = data[10:0];
      CFG_SRC_HEIGHT: cfg_h = data[10:0];
      CFG_BLIT_MODE:  cfg_mode = data[2:0];
      CFG_FILL_COLOR: cfg_fill = data[0];
      default:        cfg_planes = data[1:0];
    endcase
  endtask

  task automatic load_registers(input int dx, input int dy, input int w, input int h,
                                input logic [2:0] mode, input logic fill,
                                input logic [1:0] planes);
    write_reg(CFG_DEST_X, 12'(dx));
    write_reg(CFG_DEST_Y, 12'(dy));
    write_reg(CFG_SRC_WIDTH, 12'(w));
    write_reg(CFG_SRC_HEIGHT, 12'(h));
    write_reg(CFG_BLIT_MODE, {9'd0, mode});
    write_reg(CFG_FILL_COLOR, {11'd0, fill});
    write_reg(CFG_PLANE_ENABLE, {10'd0, planes});
  endtask

  task automatic send(input logic [7:0] bw, input logic [7:0] gs);
    src_byte_t b;
    b.bw = bw;
    b.gs = gs;
    bytes_to_send.push_back(b);
    bytes_sent++;
  endtask

  // Wait until every request is taken and every write has come out, then let
  // a byte with no visible pixel leave the pipeline too.
  task automatic drain();
    while (bytes_taken != bytes_sent || pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int         left, n, w, h, dx, dy, sel, stride;
    logic [2:0] mode;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: zero width and height give no writes at all.
    send(8'hFF, 8'hFF);
    drain();

    // Plain mode clipped on both panel edges, with a partial last byte.
    load_registers(474, 798, 12, 3, MODE_PLAIN, 1'b0, 2'd3);
    send(8'hFF, 8'h00);
    send(8'h00, 8'hFF);
    send(8'h80, 8'h01);
    send(8'h01, 8'h80);
    send(8'hAA, 8'h55);
    send(8'h55, 8'hAA);
    drain();

    // Inverted mode fully off panel at the most negative origin, then partly.
    load_registers(-2048, -2048, 8, 1, MODE_INVERT, 1'b0, 2'd3);
    send(8'h3C, 8'hC3);
    drain();
    load_registers(-3, 0, 8, 1, MODE_INVERT, 1'b0, 2'd3);
    send(8'hF0, 8'h0F);
    drain();

    // Two-plane gray.
    load_registers(0, 0, 16, 1, MODE_GRAY, 1'b0, 2'd3);
    send(8'h00, 8'hFF);
    send(8'hFF, 8'h00);
    drain();

    // Landscape source under each plane selection, none enabled included.
    for (int pe = 0; pe < 4; pe++) begin
      load_registers(100, 790, 10, 2, MODE_LAND, 1'b0, 2'(pe));
      send(8'($urandom), 8'($urandom));
      drain();
    end

    // Fill in both colors; the second sits past the far panel edge.
    load_registers(479, 0, 8, 1, MODE_FILL, 1'b1, 2'd3);
    send(8'h00, 8'h00);
    drain();
    load_registers(0, 2047, 8, 1, MODE_FILL, 1'b0, 2'd3);
    send(8'hFF, 8'hFF);
    drain();

    // Undefined mode code behaves as plain.
    load_registers(10, 10, 8, 1, MODE_CODE_TOP, 1'b1, 2'd0);
    send(8'h69, 8'h96);
    drain();

    // Shrink the height under a running row counter.
    load_registers(20, 20, 8, 4, MODE_PLAIN, 1'b0, 2'd3);
    repeat (3) send(8'($urandom), 8'($urandom));
    drain();
    load_registers(20, 20, 8, 1, MODE_PLAIN, 1'b0, 2'd3);
    repeat (2) send(8'($urandom), 8'($urandom));
    drain();

    // Largest source rectangle in landscape.
    load_registers(-1800, 100, 2047, 2047, MODE_LAND, 1'b0, 2'd3);
    repeat (2) send(8'($urandom), 8'($urandom));
    drain();

    // Random setups, mostly small rectangles placed near the panel.
    left = RANDOM_BYTES;
    while (left > 0) begin
      if (bytes_sent >= 160) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent >= 90) begin
        send_idle_pct = 59;
        recv_idle_pct = 21;
      end
      sel = $urandom_range(99);
      w = (sel < 6) ? 0 : (sel < 12) ? 2047 : (sel < 18) ? int'($urandom_range(2047)) :
          int'($urandom_range(40, 1));
      sel = $urandom_range(99);
      h = (sel < 5) ? 0 : (sel < 10) ? 2047 : (sel < 15) ? int'($urandom_range(2047)) :
          int'($urandom_range(12, 1));
      mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if ($urandom_range(9) == 0) begin
        dx = int'($urandom_range(4095)) - 2048;
      end else begin
        dx = int'($urandom_range(490)) - 20;
        if (mode == MODE_LAND && h > 0) dx = dx - int'($urandom_range(h - 1));
      end
      if ($urandom_range(9) == 0) begin
        dy = int'($urandom_range(4095)) - 2048;
      end else begin
        dy = int'($urandom_range(810)) - 20;
        if (mode == MODE_LAND && w > 0) dy = dy - int'($urandom_range(w - 1));
      end
      if (dx < -2048) dx = -2048;
      if (dy < -2048) dy = -2048;
      load_registers(dx, dy, w, h, mode, 1'($urandom), 2'($urandom));
      stride = (w + 7) / 8;
      if ($urandom_range(3) != 0 && stride * h > 0 && stride * h <= 24) n = stride * h;
      else n = $urandom_range(16, 1);
      if (n > left) n = left;
      repeat (n) send(8'($urandom), 8'($urandom));
      left -= n;
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
